@@ rtl/bmhq_pkg.sv @@
// Package for the binary max-heap priority queue.
// Holds the widths, command and status codes, state type and the structs
// passed along the row of cells. Depends on nothing.
`timescale 1ns / 1ps
`default_nettype none

package bmhq_pkg;

    localparam int CAPACITY_DEF = 64;
    localparam int KEY_W        = 32;
    localparam int CMD_W        = 2;
    localparam int ENTRIES_W    = 7;
    localparam int STATUS_W     = 2;

    localparam logic [CMD_W-1:0] CMD_INSERT = 2'd0;
    localparam logic [CMD_W-1:0] CMD_DELETE = 2'd1;
    localparam logic [CMD_W-1:0] CMD_PEEK   = 2'd2;

    localparam logic [STATUS_W-1:0] STAT_OK    = 2'd0;
    localparam logic [STATUS_W-1:0] STAT_EMPTY = 2'd1;
    localparam logic [STATUS_W-1:0] STAT_FULL  = 2'd2;

    typedef enum logic {
        ST_IDLE,
        ST_EXEC
    } t_state;

    // Operation broadcast to every cell of the row.
    typedef struct packed {
        logic                    ins;
        logic                    del;
        logic signed [KEY_W-1:0] key;
    } t_cell_op;

    // What a cell shows to its neighbours.
    typedef struct packed {
        logic                    valid;
        logic                    ge;
        logic signed [KEY_W-1:0] value;
    } t_link;

endpackage

`default_nettype wire

@@ rtl/bmhq_cell.sv @@
// One cell of the sorted row: holds one key and its valid bit.
// Depends on bmhq_pkg for the operation and neighbour link structs.
`timescale 1ns / 1ps
`default_nettype none

module bmhq_cell (
    input  wire                    i_clk,
    input  wire                    i_rst_n,
    input  bmhq_pkg::t_cell_op     i_op,
    input  bmhq_pkg::t_link        i_left,
    input  bmhq_pkg::t_link        i_right,
    output bmhq_pkg::t_link        o_link
);

    logic                             r_valid;
    logic                             n_valid;
    logic signed [bmhq_pkg::KEY_W-1:0] r_value;
    logic signed [bmhq_pkg::KEY_W-1:0] n_value;
    logic                             w_ge;

    assign w_ge = r_valid && ($signed(r_value) >= $signed(i_op.key));

    always_comb begin
        o_link.valid = r_valid;
        o_link.ge    = w_ge;
        o_link.value = r_value;
    end

    // On a delete the row shifts towards the head; on an insert every cell
    // below the new key takes the key or its left neighbour's entry.
    always_comb begin
        n_valid = r_valid;
        n_value = r_value;
        if (i_op.del) begin
            n_valid = i_right.valid;
            n_value = i_right.value;
        end else if (i_op.ins && !w_ge) begin
            if (i_left.ge) begin
                n_valid = 1'b1;
                n_value = i_op.key;
            end else begin
                n_valid = i_left.valid;
                n_value = i_left.value;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_value <= n_value;
    end

endmodule

`default_nettype wire

@@ rtl/binary_max_heap_queue.sv @@
// Priority queue of signed keys: each item is registered, then the row of cells
// and the result registers are updated together in the working state.
// No new item is taken until the single update of the cell row is done.
// Synchronous active-low reset empties the queue; the receiver cannot stall.
// Depends on bmhq_pkg and bmhq_cell.
`timescale 1ns / 1ps
`default_nettype none

module binary_max_heap_queue #(
    parameter int CAPACITY = bmhq_pkg::CAPACITY_DEF
) (
    input  wire                                 i_clk,
    input  wire                                 i_rst_n,
    input  wire                                 start,
    output logic                                busy,
    input  wire  [bmhq_pkg::CMD_W-1:0]          i_cmd,
    input  wire  signed [bmhq_pkg::KEY_W-1:0]   i_value,
    output logic                                o_valid,
    output logic signed [bmhq_pkg::KEY_W-1:0]   o_top_value,
    output logic [bmhq_pkg::ENTRIES_W-1:0]      o_entries,
    output logic [bmhq_pkg::STATUS_W-1:0]       o_status
);

    localparam int CW = $clog2(CAPACITY + 1);

    bmhq_pkg::t_state                     r_state, n_state;
    logic [bmhq_pkg::CMD_W-1:0]           r_cmd, n_cmd;
    logic signed [bmhq_pkg::KEY_W-1:0]    r_key, n_key;
    logic [CW-1:0]                        r_count, n_count;
    logic signed [bmhq_pkg::KEY_W-1:0]    r_top, n_top;
    logic [bmhq_pkg::ENTRIES_W-1:0]       r_entries, n_entries;
    logic [bmhq_pkg::STATUS_W-1:0]        r_status, n_status;
    logic                                 r_valid, n_valid;

    bmhq_pkg::t_cell_op                   w_op;
    bmhq_pkg::t_link                      w_link [CAPACITY];
    bmhq_pkg::t_link                      w_head;
    bmhq_pkg::t_link                      w_tail;
    logic                                 w_full;
    logic                                 w_empty;

    // The head cell sees a left neighbour that always outranks the key.
    always_comb begin
        w_head.valid = 1'b1;
        w_head.ge    = 1'b1;
        w_head.value = '0;
        w_tail       = '0;
    end

    genvar g;
    generate
        for (g = 0; g < CAPACITY; g++) begin : g_cell
            bmhq_pkg::t_link w_left;
            bmhq_pkg::t_link w_right;
            if (g == 0) begin : g_first
                assign w_left = w_head;
            end else begin : g_mid
                assign w_left = w_link[g-1];
            end
            if (g == CAPACITY - 1) begin : g_last
                assign w_right = w_tail;
            end else begin : g_inner
                assign w_right = w_link[g+1];
            end
            bmhq_cell u_cell (
                .i_clk   (i_clk),
                .i_rst_n (i_rst_n),
                .i_op    (w_op),
                .i_left  (w_left),
                .i_right (w_right),
                .o_link  (w_link[g])
            );
        end
    endgenerate

    assign w_full  = (r_count == CW'(CAPACITY));
    assign w_empty = (r_count == '0);

    always_comb begin
        n_state   = r_state;
        n_cmd     = r_cmd;
        n_key     = r_key;
        n_count   = r_count;
        n_top     = r_top;
        n_status  = r_status;
        n_valid   = 1'b0;
        w_op.ins  = 1'b0;
        w_op.del  = 1'b0;
        w_op.key  = r_key;
        unique case (r_state)
            bmhq_pkg::ST_IDLE: begin
                if (start) begin
                    n_cmd   = i_cmd;
                    n_key   = i_value;
                    n_state = bmhq_pkg::ST_EXEC;
                end
            end
            bmhq_pkg::ST_EXEC: begin
                n_state  = bmhq_pkg::ST_IDLE;
                n_valid  = 1'b1;
                n_status = bmhq_pkg::STAT_OK;
                unique case (r_cmd)
                    bmhq_pkg::CMD_INSERT: begin
                        if (w_full) begin
                            n_status = bmhq_pkg::STAT_FULL;
                            n_top    = w_link[0].value;
                        end else begin
                            w_op.ins = 1'b1;
                            n_count  = r_count + CW'(1);
                            if (!w_empty && w_link[0].ge) begin
                                n_top = w_link[0].value;
                            end else begin
                                n_top = r_key;
                            end
                        end
                    end
                    bmhq_pkg::CMD_DELETE: begin
                        if (w_empty) begin
                            n_status = bmhq_pkg::STAT_EMPTY;
                            n_top    = '0;
                        end else begin
                            w_op.del = 1'b1;
                            n_count  = r_count - CW'(1);
                            n_top    = w_link[0].value;
                        end
                    end
                    default: begin
                        if (w_empty) begin
                            n_status = bmhq_pkg::STAT_EMPTY;
                            n_top    = '0;
                        end else begin
                            n_top = w_link[0].value;
                        end
                    end
                endcase
            end
            default: begin
                n_state = bmhq_pkg::ST_IDLE;
            end
        endcase
        n_entries = bmhq_pkg::ENTRIES_W'(n_count);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= bmhq_pkg::ST_IDLE;
            r_count <= '0;
            r_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_count <= n_count;
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_cmd     <= n_cmd;
        r_key     <= n_key;
        r_top     <= n_top;
        r_entries <= n_entries;
        r_status  <= n_status;
    end

    assign busy        = (r_state == bmhq_pkg::ST_EXEC);
    assign o_valid     = r_valid;
    assign o_top_value = r_top;
    assign o_entries   = r_entries;
    assign o_status    = r_status;

endmodule

`default_nettype wire

@@ rtl/bmhq_checker.sv @@
// Port-level checker for the priority queue, attached by a bind statement.
// Depends on bmhq_pkg and on the ports of binary_max_heap_queue.
`timescale 1ns / 1ps
`default_nettype none

module bmhq_checker #(
    parameter int CAPACITY = bmhq_pkg::CAPACITY_DEF
) (
    input wire                                i_clk,
    input wire                                i_rst_n,
    input wire                                start,
    input wire                                busy,
    input wire                                o_valid,
    input wire signed [bmhq_pkg::KEY_W-1:0]   o_top_value,
    input wire [bmhq_pkg::ENTRIES_W-1:0]      o_entries,
    input wire [bmhq_pkg::STATUS_W-1:0]       o_status
);

    // An accepted item keeps the queue busy for the following cycle.
    a_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |=> busy)
        else $error("accepted item did not make the queue busy");

    // The working cycle is always followed by a result.
    a_busy_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        busy |=> o_valid)
        else $error("no result after the working cycle");

    // An empty report shows no entries and a zero maximum.
    a_empty_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && (o_status == bmhq_pkg::STAT_EMPTY)) |->
        ((o_top_value == '0) && (o_entries == '0)))
        else $error("empty status with entries or a maximum");

    // A dropped insert is reported only with the queue at capacity.
    a_full_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && (o_status == bmhq_pkg::STAT_FULL)) |->
        (o_entries == bmhq_pkg::ENTRIES_W'(CAPACITY)))
        else $error("full status below capacity");

endmodule

bind binary_max_heap_queue bmhq_checker #(
    .CAPACITY (CAPACITY)
) u_bmhq_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .start       (start),
    .busy        (busy),
    .o_valid     (o_valid),
    .o_top_value (o_top_value),
    .o_entries   (o_entries),
    .o_status    (o_status)
);

`default_nettype wire
